// ===== design/sbfc_pkg.sv =====
// sbfc_pkg: types and command codes for the block cache
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sbfc_pkg;

    typedef enum logic [2:0] {
        CMD_LOOKUP = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_ERASE  = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_TRIM   = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] first_chrom;
        logic [15:0] second_chrom;
        logic [31:0] block_index;
        logic [31:0] block_handle;
        logic [23:0] block_pixels;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [31:0] handle_out;
        logic [6:0]  evicted;
        logic [6:0]  entries_used;
        logic [31:0] pixels_used;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_EVICT,
        ST_STORE,
        ST_DONE
    } t_state;

    // broadcast control from the sequencer to each cell
    typedef struct packed {
        logic        clear_all;
        logic        match_kill;
        logic        pop;
        logic        store;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== design/sbfc_cell.sv =====
// sbfc_cell: one cache slot with key compare, valid bit and ring position
// depends on sbfc_pkg
`timescale 1ns / 1ps
`default_nettype none
module sbfc_cell #(
    parameter int IDX_W = 6
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire [IDX_W-1:0]        i_my_idx,
    input  wire sbfc_pkg::t_req    i_req,
    input  wire sbfc_pkg::t_cell_ctl i_ctl,
    input  wire [IDX_W-1:0]        i_oldest,
    input  wire [IDX_W-1:0]        i_next,
    input  wire [31:0]             i_hdl_chain,
    input  wire [23:0]             i_px_chain,
    output logic [31:0]            o_hdl_chain,
    output logic [23:0]            o_px_chain,
    output logic                   o_hit,
    output logic                   o_valid
);
    logic        r_valid;
    logic [15:0] r_first;
    logic [15:0] r_second;
    logic [31:0] r_block;
    logic [31:0] r_handle;
    logic [23:0] r_pixels;
    logic        is_old;

    // key compare on valid entry
    assign o_hit = r_valid && r_first == i_req.first_chrom
                   && r_second == i_req.second_chrom && r_block == i_req.block_index;
    assign is_old = (i_oldest == i_my_idx);
    assign o_valid = r_valid;

    // pass the selected entry's payload along the chain
    // during a pop only the oldest valid slot drives its pixel count, even if a key matches
    always_comb begin
        o_hdl_chain = i_hdl_chain;
        o_px_chain  = i_px_chain;
        if (i_ctl.pop) begin
            if (is_old && r_valid) begin
                o_px_chain = r_pixels;
            end
        end else if (o_hit) begin
            o_hdl_chain = r_handle;
            o_px_chain  = r_pixels;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear_all) begin
            r_valid <= 1'b0;
        end else if (i_ctl.store && i_next == i_my_idx) begin
            r_valid <= 1'b1;
        end else if ((i_ctl.match_kill && o_hit) || (i_ctl.pop && is_old)) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.store && i_next == i_my_idx) begin
            r_first  <= i_req.first_chrom;
            r_second <= i_req.second_chrom;
            r_block  <= i_req.block_index;
            r_handle <= i_req.block_handle;
            r_pixels <= i_req.block_pixels;
        end
    end
endmodule
`default_nettype wire

// ===== design/size_budget_fifo_block_cache.sv =====
// size_budget_fifo_block_cache: FIFO-replacement block cache with pixel budget
// depends on sbfc_pkg and sbfc_cell
//
//  channel | signals                      | payload
//  request | i_req_valid / o_req_ready    | sbfc_pkg::t_req
//  result  | o_rsp_valid / i_rsp_ready    | sbfc_pkg::t_rsp
//  config  | i_cfg_we                     | i_cfg_data capacity in pixels
//
// one request at a time (accept in idle, match, done); lookup, erase, clear and
// unknown codes go from match to done, which loads the result register; trim and
// insert of a new key pass through evict, popping ring slots, stale or live, while
// room is needed, and insert then through store, which pops one more with the ring
// full before storing. reset clears valid bits, ring pointers and counters.
// the result register holds while i_rsp_ready is low; the next request may be
// taken meanwhile, but its result waits in done until the register is free.
`timescale 1ns / 1ps
`default_nettype none
module size_budget_fifo_block_cache #(
    parameter int ENTRIES = 64
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_req_valid,
    output logic             o_req_ready,
    input  wire sbfc_pkg::t_req i_req,
    output logic             o_rsp_valid,
    input  wire              i_rsp_ready,
    output sbfc_pkg::t_rsp   o_rsp,
    input  wire              i_cfg_we,
    input  wire [31:0]       i_cfg_data
);
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    sbfc_pkg::t_state  r_state, n_state;
    sbfc_pkg::t_req    r_req;
    sbfc_pkg::t_cell_ctl ctl;
    logic [31:0]       r_cap;
    logic [IDX_W-1:0]  r_oldest, r_next;
    logic [CNT_W-1:0]  r_ring, r_count;
    logic [31:0]       r_used, r_hits, r_miss;
    logic [6:0]        r_ev;
    logic              r_found;
    logic [31:0]       r_hout;
    sbfc_pkg::t_rsp    r_rsp;
    logic              r_rsp_v;

    logic [31:0] hdl_ch [ENTRIES+1];
    logic [23:0] px_ch  [ENTRIES+1];
    logic [ENTRIES-1:0] hit_v, val_v;
    logic        hit_any;
    logic        old_valid;
    logic        need_room;
    logic        ring_full;
    logic        accept;

    assign hdl_ch[0] = '0;
    assign px_ch[0]  = '0;
    assign hit_any   = |hit_v;
    assign old_valid = val_v[r_oldest];
    assign ring_full = (r_ring == CNT_W'(ENTRIES));
    assign accept    = i_req_valid && o_req_ready;

    // row of slot cells
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        sbfc_cell #(.IDX_W(IDX_W)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_my_idx   (IDX_W'(g)),
            .i_req      (r_req),
            .i_ctl      (ctl),
            .i_oldest   (r_oldest),
            .i_next     (r_next),
            .i_hdl_chain(hdl_ch[g]),
            .i_px_chain (px_ch[g]),
            .o_hdl_chain(hdl_ch[g+1]),
            .o_px_chain (px_ch[g+1]),
            .o_hit      (hit_v[g]),
            .o_valid    (val_v[g])
        );
    end

    // eviction needed for budget or trim
    always_comb begin
        if (r_req.cmd == sbfc_pkg::CMD_INSERT) begin
            need_room = ({1'b0, r_used} + {9'd0, r_req.block_pixels} > {1'b0, r_cap})
                        && (r_count != '0);
        end else begin
            need_room = (r_used > r_cap) && (r_count != '0);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbfc_pkg::ST_IDLE:  if (accept) n_state = sbfc_pkg::ST_MATCH;
            sbfc_pkg::ST_MATCH: begin
                if (r_req.cmd == sbfc_pkg::CMD_INSERT && !hit_any) begin
                    n_state = sbfc_pkg::ST_EVICT;
                end else if (r_req.cmd == sbfc_pkg::CMD_TRIM) begin
                    n_state = sbfc_pkg::ST_EVICT;
                end else begin
                    n_state = sbfc_pkg::ST_DONE;
                end
            end
            sbfc_pkg::ST_EVICT: begin
                if (!need_room) begin
                    n_state = (r_req.cmd == sbfc_pkg::CMD_INSERT) ?
                              sbfc_pkg::ST_STORE : sbfc_pkg::ST_DONE;
                end
            end
            sbfc_pkg::ST_STORE: begin
                if (!ring_full) n_state = sbfc_pkg::ST_DONE;
            end
            sbfc_pkg::ST_DONE:  if (!r_rsp_v) n_state = sbfc_pkg::ST_IDLE;
            default:            n_state = sbfc_pkg::ST_IDLE;
        endcase
    end

    // cell control
    always_comb begin
        ctl = '0;
        case (r_state)
            sbfc_pkg::ST_MATCH: begin
                ctl.match_kill = (r_req.cmd == sbfc_pkg::CMD_ERASE);
                ctl.clear_all  = (r_req.cmd == sbfc_pkg::CMD_CLEAR);
            end
            sbfc_pkg::ST_EVICT: ctl.pop = need_room;
            sbfc_pkg::ST_STORE: begin
                ctl.pop   = ring_full;
                ctl.store = !ring_full;
            end
            default: ctl = '0;
        endcase
    end

    assign o_req_ready = (r_state == sbfc_pkg::ST_IDLE);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 32'd1048576;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) r_req <= i_req;
    end

    // ring, counters and per-request results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_next   <= '0;
            r_ring   <= '0;
            r_count  <= '0;
            r_used   <= '0;
            r_hits   <= '0;
            r_miss   <= '0;
            r_ev     <= '0;
            r_found  <= 1'b0;
            r_hout   <= '0;
        end else begin
            case (r_state)
                sbfc_pkg::ST_IDLE: begin
                    r_ev    <= '0;
                    r_found <= 1'b0;
                    r_hout  <= '0;
                end
                sbfc_pkg::ST_MATCH: begin
                    case (r_req.cmd)
                        sbfc_pkg::CMD_LOOKUP: begin
                            r_found <= hit_any;
                            r_hout  <= hit_any ? hdl_ch[ENTRIES] : 32'd0;
                            if (hit_any) r_hits <= r_hits + 32'd1;
                            else         r_miss <= r_miss + 32'd1;
                        end
                        sbfc_pkg::CMD_INSERT: r_hout <= r_req.block_handle;
                        sbfc_pkg::CMD_ERASE: begin
                            r_found <= hit_any;
                            if (hit_any) begin
                                r_used  <= r_used - {8'd0, px_ch[ENTRIES]};
                                r_count <= r_count - CNT_W'(1);
                            end
                        end
                        sbfc_pkg::CMD_CLEAR: begin
                            r_oldest <= '0;
                            r_next   <= '0;
                            r_ring   <= '0;
                            r_count  <= '0;
                            r_used   <= '0;
                            r_hits   <= '0;
                            r_miss   <= '0;
                        end
                        default: r_found <= 1'b0;
                    endcase
                end
                sbfc_pkg::ST_EVICT, sbfc_pkg::ST_STORE: begin
                    if (ctl.pop) begin
                        r_oldest <= (r_oldest == IDX_W'(ENTRIES - 1)) ? '0 : r_oldest + 1'b1;
                        r_ring   <= r_ring - CNT_W'(1);
                        if (old_valid) begin
                            r_used  <= r_used - {8'd0, px_ch[ENTRIES]};
                            r_count <= r_count - CNT_W'(1);
                            r_ev    <= r_ev + 7'd1;
                        end
                    end
                    if (ctl.store) begin
                        r_next  <= (r_next == IDX_W'(ENTRIES - 1)) ? '0 : r_next + 1'b1;
                        r_ring  <= r_ring + CNT_W'(1);
                        r_count <= r_count + CNT_W'(1);
                        r_used  <= r_used + {8'd0, r_req.block_pixels};
                    end
                end
                default: r_ev <= r_ev;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_v <= 1'b0;
        end else if (r_state == sbfc_pkg::ST_DONE && !r_rsp_v) begin
            r_rsp_v <= 1'b1;
        end else if (r_rsp_v && i_rsp_ready) begin
            r_rsp_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sbfc_pkg::ST_DONE && !r_rsp_v) begin
            r_rsp.found        <= r_found;
            r_rsp.handle_out   <= r_hout;
            r_rsp.evicted      <= r_ev;
            r_rsp.entries_used <= 7'(r_count);
            r_rsp.pixels_used  <= r_used;
            r_rsp.hit_total    <= r_hits;
            r_rsp.miss_total   <= r_miss;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= sbfc_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    assign o_rsp_valid = r_rsp_v;
    assign o_rsp       = r_rsp;
endmodule
`default_nettype wire

// ===== tb/sv/sbfc_checker.sv =====
// sbfc_checker: watches the request and result channels of the block cache,
// predicts each result and compares it; depends on sbfc_pkg
`timescale 1ns / 1ps
module sbfc_checker #(
    parameter int ENTRIES = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_req_valid,
    input  wire                 i_req_ready,
    input  wire sbfc_pkg::t_req i_req,
    input  wire                 i_rsp_valid,
    input  wire                 i_rsp_ready,
    input  wire sbfc_pkg::t_rsp i_rsp,
    input  wire                 i_cfg_we,
    input  wire [31:0]          i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    // shadow copy of the cache contents
    logic [15:0] sh_first [ENTRIES];
    logic [15:0] sh_second [ENTRIES];
    logic [31:0] sh_block [ENTRIES];
    logic [31:0] sh_handle [ENTRIES];
    logic [23:0] sh_pixels [ENTRIES];
    bit          sh_valid [ENTRIES];
    int          ring_head, ring_tail, ring_len;
    logic [31:0] pix_sum, hit_cnt, miss_cnt, budget;
    sbfc_pkg::t_rsp expected_rsp [$];

    assign o_pending = expected_rsp.size();

    function automatic int valid_count();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++) n += sh_valid[i];
        return n;
    endfunction

    function automatic int slot_of(sbfc_pkg::t_req r);
        for (int i = 0; i < ENTRIES; i++)
            if (sh_valid[i] && sh_first[i] == r.first_chrom &&
                sh_second[i] == r.second_chrom && sh_block[i] == r.block_index)
                return i;
        return -1;
    endfunction

    // free the front ring slot, 1 when it held a live entry
    function automatic int free_front();
        int s;
        if (ring_len == 0) return 0;
        s = ring_head;
        ring_head = (s + 1 >= ENTRIES) ? 0 : s + 1;
        ring_len--;
        if (sh_valid[s]) begin
            sh_valid[s] = 0;
            pix_sum -= sh_pixels[s];
            return 1;
        end
        return 0;
    endfunction

    // drop stale slots up to and including the oldest live entry
    function automatic int drop_oldest();
        while (ring_len > 0)
            if (free_front()) return 1;
        return 0;
    endfunction

    function automatic sbfc_pkg::t_rsp cache_step(sbfc_pkg::t_req r);
        sbfc_pkg::t_rsp o;
        int   s, ev;
        o = '0;
        ev = 0;
        case (r.cmd)
            sbfc_pkg::CMD_LOOKUP: begin
                s = slot_of(r);
                if (s >= 0) begin
                    o.found = 1;
                    o.handle_out = sh_handle[s];
                    hit_cnt++;
                end else miss_cnt++;
            end
            sbfc_pkg::CMD_INSERT: begin
                o.handle_out = r.block_handle;
                if (slot_of(r) < 0) begin
                    while ({32'd0, pix_sum} + r.block_pixels > {32'd0, budget} &&
                           valid_count() > 0)
                        ev += drop_oldest();
                    if (ring_len >= ENTRIES) ev += free_front();
                    s = ring_tail;
                    sh_first[s] = r.first_chrom;
                    sh_second[s] = r.second_chrom;
                    sh_block[s] = r.block_index;
                    sh_handle[s] = r.block_handle;
                    sh_pixels[s] = r.block_pixels;
                    sh_valid[s] = 1;
                    pix_sum += r.block_pixels;
                    ring_tail = (s + 1 >= ENTRIES) ? 0 : s + 1;
                    ring_len++;
                end
            end
            sbfc_pkg::CMD_ERASE: begin
                s = slot_of(r);
                if (s >= 0) begin
                    sh_valid[s] = 0;
                    pix_sum -= sh_pixels[s];
                    o.found = 1;
                end
            end
            sbfc_pkg::CMD_CLEAR: begin
                for (int i = 0; i < ENTRIES; i++) sh_valid[i] = 0;
                ring_head = 0;
                ring_tail = 0;
                ring_len = 0;
                pix_sum = 0;
                hit_cnt = 0;
                miss_cnt = 0;
            end
            sbfc_pkg::CMD_TRIM: begin
                while (pix_sum > budget && valid_count() > 0) ev += drop_oldest();
            end
            default: ;
        endcase
        o.evicted = ev[6:0];
        o.entries_used = 7'(valid_count());
        o.pixels_used = pix_sum;
        o.hit_total = hit_cnt;
        o.miss_total = miss_cnt;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    // track config writes and requests, compare results
    always @(posedge i_clk) begin
        sbfc_pkg::t_rsp w;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) sh_valid[i] = 0;
            ring_head = 0;
            ring_tail = 0;
            ring_len = 0;
            pix_sum = 0;
            hit_cnt = 0;
            miss_cnt = 0;
            budget = 32'd1048576;
            expected_rsp.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) budget = i_cfg_data;
            if (i_req_valid && i_req_ready) expected_rsp.push_back(cache_step(i_req));
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch("unexpected result", 32'd1, 32'd0);
                end else begin
                    w = expected_rsp.pop_front();
                    if (i_rsp.found !== w.found)
                        report_mismatch("found", 32'(i_rsp.found), 32'(w.found));
                    if (i_rsp.handle_out !== w.handle_out)
                        report_mismatch("handle_out", i_rsp.handle_out, w.handle_out);
                    if (i_rsp.evicted !== w.evicted)
                        report_mismatch("evicted", 32'(i_rsp.evicted), 32'(w.evicted));
                    if (i_rsp.entries_used !== w.entries_used)
                        report_mismatch("entries_used", 32'(i_rsp.entries_used),
                                        32'(w.entries_used));
                    if (i_rsp.pixels_used !== w.pixels_used)
                        report_mismatch("pixels_used", i_rsp.pixels_used, w.pixels_used);
                    if (i_rsp.hit_total !== w.hit_total)
                        report_mismatch("hit_total", i_rsp.hit_total, w.hit_total);
                    if (i_rsp.miss_total !== w.miss_total)
                        report_mismatch("miss_total", i_rsp.miss_total, w.miss_total);
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb_size_budget_fifo_block_cache.sv =====
// tb_size_budget_fifo_block_cache: stimulus and verdict for the block cache
// depends on sbfc_pkg, size_budget_fifo_block_cache and sbfc_checker
`timescale 1ns / 1ps
module tb_size_budget_fifo_block_cache;
    localparam int  ENTRIES = 64;
    localparam int  LIMIT_CYCLES = 1500000;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    sbfc_pkg::t_req req;
    logic        rsp_valid;
    logic        rsp_ready;
    sbfc_pkg::t_rsp rsp;
    logic        cfg_we;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycle_count;
    bit          hold_rsp;

    // small key space so lookups, erases and duplicates hit often
    logic [15:0] pool_first [4];
    logic [15:0] pool_second [4];
    logic [31:0] pool_block [8];

    size_budget_fifo_block_cache #(.ENTRIES(ENTRIES)) uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_req_valid(req_valid), .o_req_ready(req_ready), .i_req(req),
        .o_rsp_valid(rsp_valid), .i_rsp_ready(rsp_ready), .o_rsp(rsp),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    sbfc_checker #(.ENTRIES(ENTRIES)) u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_req_valid(req_valid), .i_req_ready(req_ready), .i_req(req),
        .i_rsp_valid(rsp_valid), .i_rsp_ready(rsp_ready), .i_rsp(rsp),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 30);
    endfunction

    // result side stalls, with an optional long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ready <= 1'b0;
        end else if (hold_rsp) begin
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // valid always goes low between two requests, also when there is no pause
    task automatic send_req(sbfc_pkg::t_req r, bit pause);
        int g;
        g = pause ? gap_len() : 0;
        repeat (g + 1) @(posedge clk);
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        req_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending != 0) @(posedge clk);
        // lets a trailing eviction pass settle
        repeat (ENTRIES + 8) @(posedge clk);
    endtask

    task automatic write_budget(logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic sbfc_pkg::t_req make_req(sbfc_pkg::t_cmd c, int fi, int si, int bi,
                                                logic [23:0] px);
        sbfc_pkg::t_req r;
        r.cmd = c;
        r.first_chrom = pool_first[fi];
        r.second_chrom = pool_second[si];
        r.block_index = pool_block[bi];
        r.block_handle = $urandom();
        r.block_pixels = px;
        return r;
    endfunction

    function automatic sbfc_pkg::t_req random_req();
        sbfc_pkg::t_req r;
        int   p;
        p = $urandom_range(0, 99);
        r = make_req(sbfc_pkg::CMD_LOOKUP, $urandom_range(0, 3), $urandom_range(0, 3),
                     $urandom_range(0, 7), 24'($urandom_range(0, 60000)));
        if (p < 40) r.cmd = sbfc_pkg::CMD_INSERT;
        else if (p < 70) r.cmd = sbfc_pkg::CMD_LOOKUP;
        else if (p < 85) r.cmd = sbfc_pkg::CMD_ERASE;
        else if (p < 92) r.cmd = sbfc_pkg::CMD_TRIM;
        else if (p < 94) r.cmd = sbfc_pkg::CMD_CLEAR;
        else if (p < 96) r.cmd = 3'($urandom_range(5, 7));
        else begin
            // fully random noise, including huge sizes
            r = sbfc_pkg::t_req'(($bits(sbfc_pkg::t_req))'(
                    {$urandom(), $urandom(), $urandom(), $urandom()}));
            if (r.cmd > 3'd4 && $urandom_range(0, 1)) r.cmd = sbfc_pkg::CMD_INSERT;
        end
        if ($urandom_range(0, 30) == 0) r.block_pixels = 24'hFFFFFF;
        return r;
    endfunction

    initial begin
        sbfc_pkg::t_req r;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        hold_rsp = 1'b0;
        pool_first = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5};
        pool_second = '{16'h0000, 16'hFFFF, 16'h3C3C, 16'hC3C3};
        pool_block = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
                       32'h5555_5555, 32'hAAAA_AAAA, 32'h7, 32'h1234_5678};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: basic hit, miss, duplicate insert, erase, oversize, trim, clear, unknown code
        send_req(make_req(sbfc_pkg::CMD_LOOKUP, 1, 1, 1, 0), 0);
        send_req(make_req(sbfc_pkg::CMD_INSERT, 1, 1, 1, 24'hFFFFFF), 0);
        send_req(make_req(sbfc_pkg::CMD_LOOKUP, 1, 1, 1, 0), 0);
        send_req(make_req(sbfc_pkg::CMD_INSERT, 1, 1, 1, 24'd5), 0);
        send_req(make_req(sbfc_pkg::CMD_INSERT, 0, 0, 0, 24'd0), 0);
        send_req(make_req(sbfc_pkg::CMD_ERASE, 0, 0, 0, 0), 0);
        send_req(make_req(sbfc_pkg::CMD_ERASE, 0, 0, 0, 0), 0);
        send_req(make_req(sbfc_pkg::CMD_INSERT, 2, 3, 4, 24'd300000), 0);
        send_req(make_req(sbfc_pkg::CMD_TRIM, 0, 0, 0, 0), 0);
        send_req(make_req(sbfc_pkg::CMD_CLEAR, 0, 0, 0, 0), 0);
        r = make_req(sbfc_pkg::CMD_LOOKUP, 0, 0, 0, 0);
        r.cmd = 3'd7;
        send_req(r, 0);
        drain_results();

        // budget zero: each insert evicts the previous one
        write_budget(32'd0);
        send_req(make_req(sbfc_pkg::CMD_INSERT, 2, 2, 2, 24'd10), 0);
        send_req(make_req(sbfc_pkg::CMD_INSERT, 3, 3, 3, 24'd10), 0);
        send_req(make_req(sbfc_pkg::CMD_INSERT, 0, 1, 6, 24'd0), 0);
        send_req(make_req(sbfc_pkg::CMD_TRIM, 0, 0, 0, 0), 0);
        drain_results();

        // full budget: fill the ring past its depth, erasing some on the way
        write_budget(32'hFFFF_FFFF);
        for (int i = 0; i < ENTRIES + 10; i++) begin
            r = make_req(sbfc_pkg::CMD_INSERT, 0, 0, 0, 24'hFFFFFF);
            r.block_index = 32'(i + 1000);
            send_req(r, 1);
            if (i % 7 == 3) begin
                r.cmd = sbfc_pkg::CMD_ERASE;
                send_req(r, 0);
            end
        end
        write_budget_after_drain: begin
            drain_results();
        end

        // small budget, trim evicts many entries at once
        write_budget(32'd1000);
        send_req(make_req(sbfc_pkg::CMD_TRIM, 0, 0, 0, 0), 0);
        drain_results();

        // long result hold-off so the block stalls its input
        hold_rsp = 1'b1;
        fork
            begin
                repeat (200) @(posedge clk);
                hold_rsp = 1'b0;
            end
            for (int i = 0; i < 6; i++) send_req(random_req(), 0);
        join
        drain_results();

        // random phases with changing budget
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_budget(32'd100000);
                1: write_budget(32'd2000000);
                2: write_budget(32'($urandom()));
                3: write_budget(32'd1048576);
                4: write_budget(32'd40000);
                default: write_budget(32'hFFFF_FFFF);
            endcase
            for (int i = 0; i < 100; i++) send_req(random_req(), i % 40 >= 10);
            drain_results();
        end

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
